// File: src/rbsi_pkg.sv
package rbsi_pkg;

  // Width of the entry parameter and of the signed slab parameter.
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned TVAL_W  = ENTRY_W + 2;

  // Signed slab parameter, wide enough to hold +/- the saturated value.
  typedef logic signed [TVAL_W-1:0] tval_t;

  localparam tval_t TVAL_MAX = {2'b00, {ENTRY_W{1'b1}}};

  // Per-axis status that travels beside the dividers.
  typedef struct packed {
    logic par;    // Direction component is zero.
    logic pmiss;  // Parallel axis with the origin outside the slab.
  } axis_flags_t;

endpackage

// File: src/rbsi_ifs.sv
interface ray_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ray_origin_x;
  logic signed [COORD_WIDTH-1:0] ray_origin_y;
  logic signed [COORD_WIDTH-1:0] ray_dir_x;
  logic signed [COORD_WIDTH-1:0] ray_dir_y;
  logic signed [COORD_WIDTH-1:0] box_center_x;
  logic signed [COORD_WIDTH-1:0] box_center_y;
  logic        [COORD_WIDTH-2:0] box_width;
  logic        [COORD_WIDTH-2:0] box_height;

  modport source (
    output valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
           box_center_x, box_center_y, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
           box_center_x, box_center_y, box_width, box_height,
    output ready
  );
endinterface

interface res_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] entry_param;

  modport source (output valid, hit, entry_param, input ready);
  modport sink (input valid, hit, entry_param, output ready);
endinterface

// File: src/rbsi_div_cell.sv
module rbsi_div_cell #(
  parameter int unsigned CW = 32,
  parameter int unsigned NW = 50
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [CW:0]   d_i,
  input  logic [CW:0]   r_i,
  input  logic [31:0]   q_i,
  input  logic          ovf_i,
  input  logic          neg_i,
  output logic [NW-1:0] n_o,
  output logic [CW:0]   d_o,
  output logic [CW:0]   r_o,
  output logic [31:0]   q_o,
  output logic          ovf_o,
  output logic          neg_o
);

  logic [CW:0] r2;
  logic        ge;

  // One restoring step: bring down the next numerator bit and try the divisor.
  always_comb begin
    r2 = {r_i[CW-1:0], n_i[NW-1]};
    ge = (r2 >= d_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= {n_i[NW-2:0], 1'b0};
      d_o   <= d_i;
      r_o   <= ge ? (r2 - d_i) : r2;
      q_o   <= {q_i[30:0], ge};
      // A set bit pushed past the top of the quotient means overflow.
      ovf_o <= ovf_i | q_i[31];
      neg_o <= neg_i;
    end
  end

endmodule

// File: src/rbsi_divider.sv
module rbsi_divider
  import rbsi_pkg::*;
#(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [CW+2:0] num_i,
  input  logic signed [CW-1:0] den_i,
  output tval_t               q_o
);

  localparam int unsigned NMW = CW + 2;
  localparam int unsigned NW  = NMW + FB;

  logic [NW-1:0] n_w   [NW+1];
  logic [CW:0]   d_w   [NW+1];
  logic [CW:0]   r_w   [NW+1];
  logic [31:0]   q_w   [NW+1];
  logic          ovf_w [NW+1];
  logic          neg_w [NW+1];

  logic [CW+2:0] num_abs;
  logic [CW-1:0] den_abs;

  // Magnitudes and sign of the quotient.
  always_comb begin
    num_abs = num_i[CW+2] ? (CW+3)'(-num_i) : num_i;
    den_abs = den_i[CW-1] ? CW'(-den_i) : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_w[0]   <= {num_abs[NMW-1:0], {FB{1'b0}}};
      d_w[0]   <= {den_abs, 1'b0};
      r_w[0]   <= '0;
      q_w[0]   <= '0;
      ovf_w[0] <= 1'b0;
      neg_w[0] <= num_i[CW+2] ^ den_i[CW-1];
    end
  end

  // Chain of single-bit division cells.
  for (genvar i = 0; i < NW; i++) begin : g_cell
    rbsi_div_cell #(.CW(CW), .NW(NW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .n_i   (n_w[i]),
      .d_i   (d_w[i]),
      .r_i   (r_w[i]),
      .q_i   (q_w[i]),
      .ovf_i (ovf_w[i]),
      .neg_i (neg_w[i]),
      .n_o   (n_w[i+1]),
      .d_o   (d_w[i+1]),
      .r_o   (r_w[i+1]),
      .q_o   (q_w[i+1]),
      .ovf_o (ovf_w[i+1]),
      .neg_o (neg_w[i+1])
    );
  end

  logic [ENTRY_W:0] mag;
  logic             sat;

  // Saturate, round negative quotients toward minus infinity, apply sign.
  always_comb begin
    sat = ovf_w[NW] | (&q_w[NW]);
    mag = {1'b0, q_w[NW]} + (ENTRY_W+1)'(neg_w[NW] & (|r_w[NW]));
    if (sat) begin
      mag = {1'b0, {ENTRY_W{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= neg_w[NW] ? -tval_t'(mag) : tval_t'(mag);
    end
  end

endmodule

// File: src/ray_box_slab_intersect_core.sv
// Channel   Dir  Payload
// ray_i     in   ray origin, direction, box center and size (per axis)
// res_o     out  hit flag and unsigned entry parameter
//
// One ray is taken every cycle while no result is held at res_o; the dividers are
// chains of one-bit-per-cell stages, four in parallel.
// Reset clears the valid bits of the pipeline only.
// A result held at res_o stalls the whole pipeline; ray_i.ready drops with it.
module ray_box_slab_intersect_core
  import rbsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ray_in_if.sink         ray_i,
  res_out_if.source      res_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NW = CW + 2 + FRAC_BITS;
  localparam int unsigned DL = NW + 2;

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || res_o.ready;
  assign ray_i.ready = en;

  // Front stage: slab edges relative to the origin, doubled to stay exact.
  logic signed [CW-1:0] org [2];
  logic signed [CW-1:0] dir [2];
  logic signed [CW-1:0] ctr [2];
  logic        [CW-2:0] siz [2];
  logic signed [CW+2:0] c2 [2];
  logic signed [CW+2:0] o2 [2];
  logic signed [CW+2:0] se [2];

  logic signed [CW+2:0] ln_q [2];
  logic signed [CW+2:0] hn_q [2];
  logic signed [CW-1:0] v_q  [2];
  logic                 vld_f_q;

  always_comb begin
    org[0] = ray_i.ray_origin_x;
    org[1] = ray_i.ray_origin_y;
    dir[0] = ray_i.ray_dir_x;
    dir[1] = ray_i.ray_dir_y;
    ctr[0] = ray_i.box_center_x;
    ctr[1] = ray_i.box_center_y;
    siz[0] = ray_i.box_width;
    siz[1] = ray_i.box_height;
    for (int a = 0; a < 2; a++) begin
      c2[a] = {{2{ctr[a][CW-1]}}, ctr[a], 1'b0};
      o2[a] = {{2{org[a][CW-1]}}, org[a], 1'b0};
      se[a] = {4'b0000, siz[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        ln_q[a] <= c2[a] - se[a] - o2[a];
        hn_q[a] <= c2[a] + se[a] - o2[a];
        v_q[a]  <= dir[a];
      end
    end
  end

  // Four dividers: low and high slab edge on each axis.
  tval_t tn_w [2];
  tval_t tf_w [2];

  for (genvar a = 0; a < 2; a++) begin : g_axis
    rbsi_divider #(.CW(CW), .FB(FRAC_BITS)) u_div_near (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (ln_q[a]),
      .den_i (v_q[a]),
      .q_o   (tn_w[a])
    );
    rbsi_divider #(.CW(CW), .FB(FRAC_BITS)) u_div_far (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (hn_q[a]),
      .den_i (v_q[a]),
      .q_o   (tf_w[a])
    );
  end

  // Axis flags and valid bits ride along beside the dividers.
  axis_flags_t fl_in [2];
  axis_flags_t fl_q  [DL][2];
  logic        vld_q [DL];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fl_in[a].par   = (v_q[a] == '0);
      fl_in[a].pmiss = fl_in[a].par && ((ln_q[a] > 0) || (hn_q[a] < 0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fl_in;
      for (int i = 1; i < DL; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // Sort stage: put near and far into order per axis.
  tval_t       lo_q [2];
  tval_t       hi_q [2];
  axis_flags_t fl_s_q [2];
  logic        vld_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        lo_q[a] <= (tn_w[a] > tf_w[a]) ? tf_w[a] : tn_w[a];
        hi_q[a] <= (tn_w[a] > tf_w[a]) ? tn_w[a] : tf_w[a];
      end
      fl_s_q <= fl_q[DL-1];
    end
  end

  // Combine stage: fold both axes into the entry and exit parameters.
  tval_t tmin;
  tval_t tmax;
  logic  miss;

  always_comb begin
    tmin = '0;
    tmax = TVAL_MAX;
    miss = 1'b0;
    for (int a = 0; a < 2; a++) begin
      if (fl_s_q[a].pmiss) begin
        miss = 1'b1;
      end
      if (!fl_s_q[a].par) begin
        if (lo_q[a] > tmin) begin
          tmin = lo_q[a];
        end
        if (hi_q[a] < tmax) begin
          tmax = hi_q[a];
        end
      end
    end
    if ((tmin > tmax) || (tmin >= TVAL_MAX)) begin
      miss = 1'b1;
    end
  end

  logic              hit_q;
  logic [ENTRY_W-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= !miss;
      entry_q <= miss ? {ENTRY_W{1'b1}} : tmin[ENTRY_W-1:0];
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q   <= 1'b0;
      vld_s_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DL; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_f_q  <= ray_i.valid;
      vld_q[0] <= vld_f_q;
      for (int i = 1; i < DL; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      vld_s_q   <= vld_q[DL-1];
      out_vld_q <= vld_s_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.hit         = hit_q;
  assign res_o.entry_param = entry_q;

endmodule
